@@ rtl/ieh_pkg.sv @@
// ----------------------------------------------------------------------------
// ieh_pkg
// shared widths, codes and the front-to-back queue entry of the interval
// error histogram unit
// ----------------------------------------------------------------------------
package ieh_pkg;

	localparam int TS_BITS     = 48;
	localparam int FRAC_BITS   = 32;
	localparam int NUM_CLASSES = 7;

	localparam int IN_TS_W  = 48;
	localparam int DIFF_W   = TS_BITS + 1;
	localparam int ERR_W    = TS_BITS + 1;
	localparam int MAG_W    = TS_BITS;
	localparam int PROD_W   = ERR_W + 14;
	localparam int CLS_W    = 3;
	localparam int CNT_W    = 32;
	localparam int VAL_W    = 64;
	localparam int KIND_W   = 2;
	localparam int DIV_CNT_W = 6;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 552;

	localparam logic [CLS_W-1:0] CLS_ZERO   = 3'd0;
	localparam logic [CLS_W-1:0] CLS_ABOVE  = 3'd6;
	localparam logic [CLS_W-1:0] CLS_UNCLS  = 3'd7;

	localparam logic [KIND_W-1:0] KIND_INTERVAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLASS    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TOTALS   = 2'd2;

	localparam logic [13:0] DECADE [5] = '{14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1};

	typedef struct packed {
		logic                has_iv;
		logic                last;
		logic [CLS_W-1:0]    cls;
		logic [DIFF_W-1:0]   dorg;
		logic [DIFF_W-1:0]   dsync;
		logic [ERR_W-1:0]    err;
		logic [MAG_W-1:0]    mag;
		logic [DIFF_W-1:0]   span_org;
		logic [DIFF_W-1:0]   span_sync;
	} ieh_entry_t;

	function automatic logic [VAL_W-1:0] sext64(input logic [DIFF_W-1:0] x);
		sext64 = {{(VAL_W-DIFF_W){x[DIFF_W-1]}}, x};
	endfunction

endpackage

@@ rtl/ieh_front.sv @@
// ----------------------------------------------------------------------------
// ieh_front
// accepts events, forms intervals, error magnitudes and the decade class
// ----------------------------------------------------------------------------
module ieh_front
	import ieh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_TS_W-1:0]   org_time,
	input  logic [IN_TS_W-1:0]   sync_time,
	input  logic                 last,
	output logic                 push_valid,
	input  logic                 push_ready,
	output ieh_entry_t           push_entry
);

	logic                have_prev_q;
	logic [TS_BITS-1:0]  prev_org_q, prev_sync_q, first_org_q, first_sync_q;

	logic                valid_s1, has_iv_s1, last_s1;
	logic [DIFF_W-1:0]   dorg_s1, dsync_s1, span_org_s1, span_sync_s1;

	logic [TS_BITS-1:0]  org_ts, sync_ts, base_org, base_sync;
	logic                accept;

	assign org_ts    = TS_BITS'(org_time);
	assign sync_ts   = TS_BITS'(sync_time);
	assign in_ready  = !valid_s1 || push_ready;
	assign accept    = in_valid && in_ready;
	assign base_org  = have_prev_q ? first_org_q : org_ts;
	assign base_sync = have_prev_q ? first_sync_q : sync_ts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				have_prev_q <= !last;
				valid_s1    <= have_prev_q || last;
			end else if (push_ready) begin
				valid_s1    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!have_prev_q) begin
				first_org_q  <= org_ts;
				first_sync_q <= sync_ts;
			end
			prev_org_q   <= org_ts;
			prev_sync_q  <= sync_ts;
			has_iv_s1    <= have_prev_q;
			last_s1      <= last;
			dorg_s1      <= {1'b0, org_ts} - {1'b0, prev_org_q};
			dsync_s1     <= {1'b0, sync_ts} - {1'b0, prev_sync_q};
			span_org_s1  <= {1'b0, org_ts} - {1'b0, base_org};
			span_sync_s1 <= {1'b0, sync_ts} - {1'b0, base_sync};
		end
	end

	logic [DIFF_W:0]   diff;
	logic [ERR_W-1:0]  err;
	logic [MAG_W-1:0]  mag;
	logic [CLS_W-1:0]  cls;
	logic              found;
	logic [PROD_W-1:0] prod;

	always_comb begin
		diff  = {dorg_s1[DIFF_W-1], dorg_s1} - {dsync_s1[DIFF_W-1], dsync_s1};
		err   = diff[DIFF_W] ? ERR_W'(-diff) : ERR_W'(diff);
		mag   = dorg_s1[DIFF_W-1] ? MAG_W'(-dorg_s1) : MAG_W'(dorg_s1);
		found = 1'b0;
		prod  = '0;
		cls   = CLS_ABOVE;
		if (err == '0) begin
			cls = CLS_ZERO;
		end else if (mag == '0) begin
			cls = CLS_UNCLS;
		end else begin
			for (int k = 0; k < 5; k++) begin
				prod = PROD_W'(err) * PROD_W'(DECADE[k]);
				if (!found && prod <= PROD_W'(mag)) begin
					found = 1'b1;
					cls   = CLS_W'(k + 1);
				end
			end
		end
	end

	assign push_valid           = valid_s1;
	assign push_entry.has_iv    = has_iv_s1;
	assign push_entry.last      = last_s1;
	assign push_entry.cls       = cls;
	assign push_entry.dorg      = dorg_s1;
	assign push_entry.dsync     = dsync_s1;
	assign push_entry.err       = err;
	assign push_entry.mag       = mag;
	assign push_entry.span_org  = span_org_s1;
	assign push_entry.span_sync = span_sync_s1;

endmodule

@@ rtl/ieh_queue.sv @@
// ----------------------------------------------------------------------------
// ieh_queue
// two-entry queue between the classifying front and the accumulating back
// ----------------------------------------------------------------------------
module ieh_queue
	import ieh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	output logic        wr_ready,
	input  ieh_entry_t  wr_entry,
	output logic        rd_valid,
	input  logic        rd_ready,
	output ieh_entry_t  rd_entry
);

	ieh_entry_t  slot_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  fill_q;
	logic        do_wr, do_rd;

	assign wr_ready = fill_q != 2'd2;
	assign rd_valid = fill_q != 2'd0;
	assign rd_entry = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd)
				fill_q <= fill_q + 2'd1;
			else if (do_rd && !do_wr)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_entry;
	end

endmodule

@@ rtl/ieh_back.sv @@
// ----------------------------------------------------------------------------
// ieh_back
// relative error divider, class and total accumulators, row sequencer
// ----------------------------------------------------------------------------
module ieh_back
	import ieh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ieh_entry_t            pop_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [CLS_W-1:0]      class_index,
	output logic [CNT_W-1:0]      count,
	output logic [VAL_W-1:0]      org_value,
	output logic [VAL_W-1:0]      sync_value,
	output logic [VAL_W-1:0]      abs_value,
	output logic [VAL_W-1:0]      rel_value,
	output logic [VAL_W-1:0]      least_abs,
	output logic [VAL_W-1:0]      most_abs,
	output logic [VAL_W-1:0]      least_rel,
	output logic [VAL_W-1:0]      most_rel,
	output logic                  final_row
);

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ROW, ST_SUM, ST_TOT} state_t;

	localparam int SAT_W = TS_BITS + VAL_W;
	localparam int DV_W  = ERR_W + VAL_W;

	state_t                state_q;
	ieh_entry_t            ent_q;
	logic [MAG_W-1:0]      rem_q;
	logic [VAL_W-1:0]      quo_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic [CLS_W-1:0]      row_q;
	logic                  out_valid_q;

	logic [CNT_W-1:0] class_count_q [NUM_CLASSES];
	logic [VAL_W-1:0] class_abs_q   [NUM_CLASSES];
	logic [VAL_W-1:0] class_org_q   [NUM_CLASSES];
	logic [VAL_W-1:0] class_sync_q  [NUM_CLASSES];
	logic [CNT_W-1:0] total_cnt_q;
	logic [VAL_W-1:0] total_abs_q, total_rel_q, min_abs_q, max_abs_q, min_rel_q, max_rel_q;

	function automatic logic [VAL_W-1:0] add_u(input logic [VAL_W-1:0] a, b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		add_u = s[VAL_W] ? '1 : s[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] add_s(input logic [VAL_W-1:0] a, b);
		logic [VAL_W-1:0] s;
		s = a + b;
		if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
			add_s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			add_s = s;
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] a);
		inc_sat = (a == '1) ? a : a + CNT_W'(1);
	endfunction

	logic             out_free;
	logic             load_row;
	logic [SAT_W-1:0] sat_lim;
	logic [DV_W-1:0]  dividend;
	logic [MAG_W:0]   trial;
	logic             qbit;
	logic [CLS_W-1:0] idx;
	logic [VAL_W-1:0] err64, dorg64, dsync64;

	assign out_free  = !out_valid_q || out_ready;
	assign load_row  = out_free && (state_q == ST_ROW || state_q == ST_SUM
	                   || state_q == ST_TOT);
	assign out_valid = out_valid_q;
	assign pop_ready = state_q == ST_IDLE;
	assign sat_lim   = SAT_W'(pop_entry.mag) << (VAL_W - FRAC_BITS);
	assign dividend  = DV_W'(pop_entry.err) << FRAC_BITS;
	assign trial     = {rem_q, quo_q[VAL_W-1]};
	assign qbit      = trial >= {1'b0, ent_q.mag};
	assign idx       = (state_q == ST_SUM) ? row_q :
	                   (ent_q.cls == CLS_UNCLS) ? CLS_ZERO : ent_q.cls;
	assign err64     = VAL_W'(ent_q.err);
	assign dorg64    = sext64(ent_q.dorg);
	assign dsync64   = sext64(ent_q.dsync);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			step_q      <= '0;
			total_cnt_q <= '0;
			total_abs_q <= '0;
			total_rel_q <= '0;
			min_abs_q   <= '1;
			max_abs_q   <= '0;
			min_rel_q   <= '1;
			max_rel_q   <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				class_count_q[c] <= '0;
				class_abs_q[c]   <= '0;
				class_org_q[c]   <= '0;
				class_sync_q[c]  <= '0;
			end
		end else begin
			out_valid_q <= load_row || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						row_q  <= '0;
						step_q <= '0;
						if (!pop_entry.has_iv)
							state_q <= ST_SUM;
						else if (pop_entry.err == '0 || pop_entry.mag == '0
						         || SAT_W'(pop_entry.err) >= sat_lim)
							state_q <= ST_ROW;
						else
							state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + DIV_CNT_W'(1);
					if (step_q == '1)
						state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (out_free) begin
						if (ent_q.cls != CLS_UNCLS) begin
							class_count_q[idx] <= inc_sat(class_count_q[idx]);
							class_abs_q[idx]   <= add_u(class_abs_q[idx], err64);
							class_org_q[idx]   <= add_s(class_org_q[idx], dorg64);
							class_sync_q[idx]  <= add_s(class_sync_q[idx], dsync64);
						end
						total_cnt_q <= inc_sat(total_cnt_q);
						total_abs_q <= add_u(total_abs_q, err64);
						total_rel_q <= add_u(total_rel_q, quo_q);
						if (err64 < min_abs_q) min_abs_q <= err64;
						if (err64 > max_abs_q) max_abs_q <= err64;
						if (quo_q < min_rel_q) min_rel_q <= quo_q;
						if (quo_q > max_rel_q) max_rel_q <= quo_q;
						state_q <= ent_q.last ? ST_SUM : ST_IDLE;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						row_q <= row_q + CLS_W'(1);
						if (row_q == CLS_W'(NUM_CLASSES - 1))
							state_q <= ST_TOT;
					end
				end
				ST_TOT: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						total_cnt_q <= '0;
						total_abs_q <= '0;
						total_rel_q <= '0;
						min_abs_q   <= '1;
						max_abs_q   <= '0;
						min_rel_q   <= '1;
						max_rel_q   <= '0;
						for (int c = 0; c < NUM_CLASSES; c++) begin
							class_count_q[c] <= '0;
							class_abs_q[c]   <= '0;
							class_org_q[c]   <= '0;
							class_sync_q[c]  <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			ent_q <= pop_entry;
			if (pop_entry.err == '0 || pop_entry.mag == '0) begin
				quo_q <= '0;
			end else if (SAT_W'(pop_entry.err) >= sat_lim) begin
				quo_q <= '1;
			end else begin
				rem_q <= MAG_W'(dividend >> VAL_W);
				quo_q <= dividend[VAL_W-1:0];
			end
		end else if (state_q == ST_DIV) begin
			rem_q <= qbit ? MAG_W'(trial - {1'b0, ent_q.mag}) : MAG_W'(trial);
			quo_q <= {quo_q[VAL_W-2:0], qbit};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_ROW) begin
				kind        <= KIND_INTERVAL;
				class_index <= ent_q.cls;
				count       <= CNT_W'(1);
				org_value   <= dorg64;
				sync_value  <= dsync64;
				abs_value   <= err64;
				rel_value   <= quo_q;
				least_abs   <= '0;
				most_abs    <= '0;
				least_rel   <= '0;
				most_rel    <= '0;
				final_row   <= !ent_q.last;
			end else if (state_q == ST_SUM) begin
				kind        <= KIND_CLASS;
				class_index <= row_q;
				count       <= class_count_q[idx];
				org_value   <= class_org_q[idx];
				sync_value  <= class_sync_q[idx];
				abs_value   <= class_abs_q[idx];
				rel_value   <= '0;
				least_abs   <= '0;
				most_abs    <= '0;
				least_rel   <= '0;
				most_rel    <= '0;
				final_row   <= 1'b0;
			end else if (state_q == ST_TOT) begin
				kind        <= KIND_TOTALS;
				class_index <= CLS_ZERO;
				count       <= total_cnt_q;
				org_value   <= sext64(ent_q.span_org);
				sync_value  <= sext64(ent_q.span_sync);
				abs_value   <= total_abs_q;
				rel_value   <= total_rel_q;
				least_abs   <= min_abs_q;
				most_abs    <= max_abs_q;
				least_rel   <= min_rel_q;
				most_rel    <= max_rel_q;
				final_row   <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/interval_error_histogram_unit.sv @@
// ----------------------------------------------------------------------------
// interval_error_histogram_unit
// timestamp interval error statistics with decade classes and summary rows
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata org,sync; tlast last
//  m_axis    out  m_axis_tvalid/tready      tdata row fields; tuser kind; tlast final_row
//
//  an interval row holds the back end while it takes the request, runs the
//  one-bit-per-cycle relative error divider and registers the row;
//  zero or saturating errors skip the divider; front and queue each register the entry
//  a last event adds eight summary rows, one per cycle when the output drains
//  the front end and a two-entry queue keep taking events while the back works, until both are full
//  arst_n clears control state and all accumulators at once
// ----------------------------------------------------------------------------
module interval_error_histogram_unit
	import ieh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // org_time[47:0], sync_time[95:48]
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // class_index, count, org_value,
	                                               // sync_value, abs_value, rel_value,
	                                               // least_abs, most_abs, least_rel,
	                                               // most_rel, zero pad
	output logic [KIND_W-1:0]      m_axis_tuser,   // kind
	output logic                   m_axis_tlast
);

	logic        push_valid, push_ready, pop_valid, pop_ready;
	ieh_entry_t  push_entry, pop_entry;

	logic [CLS_W-1:0] class_index;
	logic [CNT_W-1:0] count;
	logic [VAL_W-1:0] org_value, sync_value, abs_value, rel_value;
	logic [VAL_W-1:0] least_abs, most_abs, least_rel, most_rel;

	ieh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.org_time   (s_axis_tdata[IN_TS_W-1:0]),
		.sync_time  (s_axis_tdata[2*IN_TS_W-1:IN_TS_W]),
		.last       (s_axis_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	ieh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_entry (push_entry),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_entry (pop_entry)
	);

	ieh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_entry   (pop_entry),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.kind        (m_axis_tuser),
		.class_index (class_index),
		.count       (count),
		.org_value   (org_value),
		.sync_value  (sync_value),
		.abs_value   (abs_value),
		.rel_value   (rel_value),
		.least_abs   (least_abs),
		.most_abs    (most_abs),
		.least_rel   (least_rel),
		.most_rel    (most_rel),
		.final_row   (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, most_rel, least_rel, most_abs, least_abs, rel_value,
	                       abs_value, sync_value, org_value, count, class_index};

endmodule
